// ===== src/bps_pkg.sv =====
// ============================================================================
// bps_pkg
// Shared types and constants for the Bloch phase-weighted nine-term sum.
// ============================================================================
package bps_pkg;

  // Default datapath sizes
  localparam int unsigned VALUE_WIDTH_DEF     = 32;  // Q16.16 input values
  localparam int unsigned PHASE_FRAC_BITS_DEF = 30;  // Q2.30 phase factors

  // Phase registers are always 32 bits, signed
  localparam int unsigned REG_W  = 32;
  localparam int unsigned ADDR_W = 4;     // four registers, byte addressed
  localparam int unsigned IDX_W  = 2;

  // Pipeline: input, pair sums, products, rounding, partial sums, output
  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned NUM_LANES  = 8; // four real lanes, four imaginary

  // Register map, index = paddr[ADDR_W-1:2]
  typedef enum logic [IDX_W-1:0] {
    REG_COS_KY = 2'd0,
    REG_SIN_KY = 2'd1,
    REG_COS_KZ = 2'd2,
    REG_SIN_KZ = 2'd3
  } cfg_reg_e;

  // Phase factors handed from the register block to the datapath
  typedef struct packed {
    logic signed [REG_W-1:0] cos_ky;
    logic signed [REG_W-1:0] sin_ky;
    logic signed [REG_W-1:0] cos_kz;
    logic signed [REG_W-1:0] sin_kz;
    logic signed [REG_W-1:0] sum_cos;
    logic signed [REG_W-1:0] sum_sin;
    logic signed [REG_W-1:0] diff_cos;
    logic signed [REG_W-1:0] diff_sin;
  } phase_t;

endpackage

// ===== src/bps_phase_regs.sv =====
// ============================================================================
// bps_phase_regs
// Phase registers behind the APB port, plus the sum and difference angle
// factors derived from them by angle addition (two register stages).
// ============================================================================
module bps_phase_regs import bps_pkg::*; #(
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output phase_t            phase_o
);

  localparam int unsigned F  = PHASE_FRAC_BITS;
  localparam int unsigned MW = 2 * REG_W;       // full product
  localparam int unsigned CW = MW - F;          // rounded product
  localparam int unsigned SW = CW + 1;          // sum of two rounded products

  localparam logic signed [REG_W-1:0] ONE_Q   = REG_W'(1) <<< F;
  localparam logic signed [CW-1:0]    ONE_C   = CW'(1) <<< F;
  localparam logic signed [MW-1:0]    HALF_LSB = MW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0]    S_MAX   = (SW'(1) <<< (REG_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0]    S_MIN   = -(SW'(1) <<< (REG_W - 1));
  localparam logic signed [REG_W-1:0] R_MAX   = {1'b0, {(REG_W-1){1'b1}}};
  localparam logic signed [REG_W-1:0] R_MIN   = {1'b1, {(REG_W-1){1'b0}}};

  logic signed [REG_W-1:0] cos_ky_q, sin_ky_q, cos_kz_q, sin_kz_q;
  logic signed [CW-1:0]    cc_q, ss_q, sc_q, cs_q;
  logic signed [CW-1:0]    cc_d, ss_d, sc_d, cs_d;
  logic signed [REG_W-1:0] sum_cos_q, sum_sin_q, diff_cos_q, diff_sin_q;
  logic signed [MW-1:0]    p_cc, p_ss, p_sc, p_cs;
  logic                    wr_en;
  cfg_reg_e                wr_idx;

  function automatic logic signed [CW-1:0] rnd_fn(input logic signed [MW-1:0] p);
    logic signed [MW-1:0] t;
    t = (p + HALF_LSB) >>> F;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [REG_W-1:0] sat_fn(input logic signed [SW-1:0] s);
    logic signed [REG_W-1:0] r;
    if (s > S_MAX)      r = R_MAX;
    else if (s < S_MIN) r = R_MIN;
    else                r = s[REG_W-1:0];
    return r;
  endfunction

  // --- APB access ---
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_idx = cfg_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_ky_q <= ONE_Q;
      sin_ky_q <= '0;
      cos_kz_q <= ONE_Q;
      sin_kz_q <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_COS_KY: cos_ky_q <= pwdata;
        REG_SIN_KY: sin_ky_q <= pwdata;
        REG_COS_KZ: cos_kz_q <= pwdata;
        REG_SIN_KZ: sin_kz_q <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_COS_KY: prdata = cos_ky_q;
      REG_SIN_KY: prdata = sin_ky_q;
      REG_COS_KZ: prdata = cos_kz_q;
      REG_SIN_KZ: prdata = sin_kz_q;
      default:    prdata = '0;
    endcase
  end

  // --- angle addition, stage 1: rounded cross products ---
  assign p_cc = MW'(cos_ky_q) * MW'(cos_kz_q);
  assign p_ss = MW'(sin_ky_q) * MW'(sin_kz_q);
  assign p_sc = MW'(sin_ky_q) * MW'(cos_kz_q);
  assign p_cs = MW'(cos_ky_q) * MW'(sin_kz_q);

  assign cc_d = rnd_fn(p_cc);
  assign ss_d = rnd_fn(p_ss);
  assign sc_d = rnd_fn(p_sc);
  assign cs_d = rnd_fn(p_cs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= ONE_C;
      ss_q <= '0;
      sc_q <= '0;
      cs_q <= '0;
    end else begin
      cc_q <= cc_d;
      ss_q <= ss_d;
      sc_q <= sc_d;
      cs_q <= cs_d;
    end
  end

  // --- stage 2: sum / difference with saturation ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_cos_q  <= ONE_Q;
      sum_sin_q  <= '0;
      diff_cos_q <= ONE_Q;
      diff_sin_q <= '0;
    end else begin
      sum_cos_q  <= sat_fn(SW'(cc_q) - SW'(ss_q));
      sum_sin_q  <= sat_fn(SW'(sc_q) + SW'(cs_q));
      diff_cos_q <= sat_fn(SW'(cc_q) + SW'(ss_q));
      diff_sin_q <= sat_fn(SW'(sc_q) - SW'(cs_q));
    end
  end

  assign phase_o.cos_ky   = cos_ky_q;
  assign phase_o.sin_ky   = sin_ky_q;
  assign phase_o.cos_kz   = cos_kz_q;
  assign phase_o.sin_kz   = sin_kz_q;
  assign phase_o.sum_cos  = sum_cos_q;
  assign phase_o.sum_sin  = sum_sin_q;
  assign phase_o.diff_cos = diff_cos_q;
  assign phase_o.diff_sin = diff_sin_q;

endmodule

// ===== src/bps_term_mul.sv =====
// ============================================================================
// bps_term_mul
// One product lane: pair value times phase factor, then round to nearest
// back to 16 fractional bits. Two register stages.
// ============================================================================
module bps_term_mul import bps_pkg::*; #(
  parameter int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_prod_i,
  input  logic                          en_rnd_i,
  input  logic signed [VALUE_WIDTH:0]   pair_i,
  input  logic signed [REG_W-1:0]       coef_i,
  output logic signed [VALUE_WIDTH+3:0] term_o
);

  localparam int unsigned F     = PHASE_FRAC_BITS;
  localparam int unsigned RW    = VALUE_WIDTH + 4;
  localparam int unsigned PW    = VALUE_WIDTH + 1 + REG_W;
  localparam int unsigned RND_W = F + RW;          // never above PW + 1
  localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (F - 1);

  logic signed [PW-1:0] prod_q;
  logic [PW:0]          prod_ext;
  logic [RND_W-1:0]     rsum;
  logic signed [RW-1:0] term_q;

  always_ff @(posedge clk_i) begin
    if (en_prod_i) begin
      prod_q <= PW'(pair_i) * PW'(coef_i);
    end
  end

  // only the low result bits matter, so the rounding add is modular
  assign prod_ext = {prod_q[PW-1], prod_q};
  assign rsum     = prod_ext[RND_W-1:0] + HALF_LSB;

  always_ff @(posedge clk_i) begin
    if (en_rnd_i) begin
      term_q <= rsum[RND_W-1:F];
    end
  end

  assign term_o = term_q;

endmodule

// ===== src/bps_datapath.sv =====
// ============================================================================
// bps_datapath
// Six-stage pipeline: capture, pair sums, products, rounding, partial sums,
// output. Per-stage valid bits with a ready chain that fills bubbles.
// ============================================================================
module bps_datapath import bps_pkg::*; #(
  parameter int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  phase_t                        phase_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] home_value_i,
  input  logic signed [VALUE_WIDTH-1:0] plus_y_value_i,
  input  logic signed [VALUE_WIDTH-1:0] minus_y_value_i,
  input  logic signed [VALUE_WIDTH-1:0] plus_z_value_i,
  input  logic signed [VALUE_WIDTH-1:0] minus_z_value_i,
  input  logic signed [VALUE_WIDTH-1:0] py_pz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] py_mz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] my_pz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] my_mz_value_i,
  input  logic                          last_element_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH+3:0] real_part_o,
  output logic signed [VALUE_WIDTH+3:0] imag_part_o,
  output logic                          final_flag_o
);

  localparam int unsigned NS = NUM_STAGES;
  localparam int unsigned NL = NUM_LANES;
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned RW = VALUE_WIDTH + 4;

  // --- stage control ---
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;
  logic [NS-1:0] vin;
  logic [NS-1:0] en;

  assign rdy[NS] = ~out_stall_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end
  assign vin = {vld_q[NS-2:0], in_valid_i};
  assign en  = rdy[NS-1:0] & vin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) vld_q[k] <= vin[k];
      end
    end
  end

  assign in_stall_o  = ~rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // --- stage 0: capture ---
  logic signed [VW-1:0] v_q [9];
  logic [NS-1:0]        last_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      v_q[0] <= home_value_i;
      v_q[1] <= plus_y_value_i;
      v_q[2] <= minus_y_value_i;
      v_q[3] <= plus_z_value_i;
      v_q[4] <= minus_z_value_i;
      v_q[5] <= py_pz_value_i;
      v_q[6] <= py_mz_value_i;
      v_q[7] <= my_pz_value_i;
      v_q[8] <= my_mz_value_i;
    end
  end

  // last-element marker travels with the valid bits
  always_ff @(posedge clk_i) begin
    if (en[0]) last_q[0] <= last_element_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) last_q[k] <= last_q[k-1];
    end
  end

  // --- stage 1: symmetric sums (lanes 0..3), antisymmetric diffs (4..7) ---
  logic signed [VW:0]   pair_q [NL];
  logic signed [VW-1:0] home1_q, home2_q, home3_q, home4_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pair_q[0] <= (VW+1)'(v_q[1]) + (VW+1)'(v_q[2]);
      pair_q[1] <= (VW+1)'(v_q[3]) + (VW+1)'(v_q[4]);
      pair_q[2] <= (VW+1)'(v_q[5]) + (VW+1)'(v_q[8]);
      pair_q[3] <= (VW+1)'(v_q[6]) + (VW+1)'(v_q[7]);
      pair_q[4] <= (VW+1)'(v_q[1]) - (VW+1)'(v_q[2]);
      pair_q[5] <= (VW+1)'(v_q[3]) - (VW+1)'(v_q[4]);
      pair_q[6] <= (VW+1)'(v_q[5]) - (VW+1)'(v_q[8]);
      pair_q[7] <= (VW+1)'(v_q[6]) - (VW+1)'(v_q[7]);
      home1_q   <= v_q[0];
    end
  end

  // --- stages 2 and 3: product lanes ---
  logic signed [REG_W-1:0] coef [NL];
  logic signed [RW-1:0]    term [NL];

  assign coef[0] = phase_i.cos_ky;
  assign coef[1] = phase_i.cos_kz;
  assign coef[2] = phase_i.sum_cos;
  assign coef[3] = phase_i.diff_cos;
  assign coef[4] = phase_i.sin_ky;
  assign coef[5] = phase_i.sin_kz;
  assign coef[6] = phase_i.sum_sin;
  assign coef[7] = phase_i.diff_sin;

  for (genvar l = 0; l < NL; l++) begin : g_lane
    bps_term_mul #(
      .VALUE_WIDTH    (VALUE_WIDTH),
      .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_mul (
      .clk_i    (clk_i),
      .en_prod_i(en[2]),
      .en_rnd_i (en[3]),
      .pair_i   (pair_q[l]),
      .coef_i   (coef[l]),
      .term_o   (term[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      home2_q   <= home1_q;
    end
    if (en[3]) begin
      home3_q   <= home2_q;
    end
  end

  // --- stage 4: partial sums ---
  logic signed [RW-1:0] re_a_q, re_b_q, im_a_q, im_b_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      re_a_q    <= term[0] + term[1];
      re_b_q    <= term[2] + term[3];
      im_a_q    <= term[4] + term[5];
      im_b_q    <= term[6] + term[7];
      home4_q   <= home3_q;
    end
  end

  // --- stage 5: output word ---
  logic signed [RW-1:0] real_q, imag_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      real_q    <= re_a_q + re_b_q + RW'(home4_q);
      imag_q    <= im_a_q + im_b_q;
    end
  end

  assign real_part_o  = real_q;
  assign imag_part_o  = imag_q;
  assign final_flag_o = last_q[NS-1];

  // --- checks ---
  logic in_acc, out_acc;
  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // words in flight change only by accepted input and delivered output
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) ==
              $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline word count broken");

  // input stalls only when every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled with a bubble in the pipe");

  // an accepted word lands in the capture stage
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> vld_q[0])
    else $error("accepted word not captured");

endmodule

// ===== src/bloch_phase_sum.sv =====
// ============================================================================
// bloch_phase_sum
// Bloch phase-weighted complex sum of nine real translation values.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per matrix
//   element: the home value and the eight neighbor values in Q16.16, plus a
//   last-element marker. Output channel (out_valid_o / out_stall_i) returns
//   one word per input word, in order: real and imaginary parts in Q20.16,
//   kept full width, sums wrap modulo the field width, and final_flag_o.
//   Phase factors cos/sin of ky and kz (Q2.30) sit behind the APB port at
//   byte offsets 0, 4, 8, 12. cos(ky+-kz) and sin(ky+-kz) are derived from
//   them through the cross-product and sum/difference registers; write only while the block is idle.
// Registers: capture, pair sums, products, rounding, partial sums, output.
// Throughput: one word per cycle while out_stall_i is low, set by the
//   eight pipelined product lanes (one multiply per lane per cycle).
// Stall: each stage holds its word while the stage ahead is full; bubbles
//   are squeezed out, so up to six words can be buffered before in_stall_o
//   rises. Nothing is dropped or repeated.
// Reset: asynchronous, active low. Clears all valid bits, sets cos to 1.0
//   and sin to 0 for both axes and for the derived phases.
// ============================================================================
module bloch_phase_sum import bps_pkg::*; #(
  parameter int unsigned VALUE_WIDTH     = VALUE_WIDTH_DEF,
  parameter int unsigned PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [REG_W-1:0]              pwdata,
  output logic [REG_W-1:0]              prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] home_value_i,
  input  logic signed [VALUE_WIDTH-1:0] plus_y_value_i,
  input  logic signed [VALUE_WIDTH-1:0] minus_y_value_i,
  input  logic signed [VALUE_WIDTH-1:0] plus_z_value_i,
  input  logic signed [VALUE_WIDTH-1:0] minus_z_value_i,
  input  logic signed [VALUE_WIDTH-1:0] py_pz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] py_mz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] my_pz_value_i,
  input  logic signed [VALUE_WIDTH-1:0] my_mz_value_i,
  input  logic                          last_element_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH+3:0] real_part_o,
  output logic signed [VALUE_WIDTH+3:0] imag_part_o,
  output logic                          final_flag_o
);

  // phase factors: programmed axes plus derived sum/diff angles
  phase_t phase;

  bps_phase_regs #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .phase_o(phase)
  );

  // Six-stage pipeline: capture, pair sums, products, rounding, partial
  // sums, output register. The real lanes take symmetric pair sums times
  // cosines, the imaginary lanes antisymmetric differences times sines.
  bps_datapath #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .phase_i        (phase),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .home_value_i   (home_value_i),
    .plus_y_value_i (plus_y_value_i),
    .minus_y_value_i(minus_y_value_i),
    .plus_z_value_i (plus_z_value_i),
    .minus_z_value_i(minus_z_value_i),
    .py_pz_value_i  (py_pz_value_i),
    .py_mz_value_i  (py_mz_value_i),
    .my_pz_value_i  (my_pz_value_i),
    .my_mz_value_i  (my_mz_value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .real_part_o    (real_part_o),
    .imag_part_o    (imag_part_o),
    .final_flag_o   (final_flag_o)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the Bloch phase-weighted nine-term sum.
// A queue-fed driver streams element words in random bursts while the
// receiver stalls on its own pattern. Every accepted word is run through an
// in-bench predictor, and the expected sum is queued. The monitor pops one
// expected sum for each returned word and compares real, imaginary and flag.
// The phase registers are rewritten between phases while the block is idle.
// ============================================================================
module testbench import bps_pkg::*;;

  localparam int unsigned VW   = VALUE_WIDTH_DEF;
  localparam int unsigned FRAC = PHASE_FRAC_BITS_DEF;
  localparam int unsigned RW   = VW + 4;          // result field width

  localparam int SETTLE_CYCLES  = 12;   // slack after the pipe drains
  localparam int WATCHDOG_LIMIT = 2000; // quiet cycles before giving up
  localparam int RANDOM_PER_SET = 34;   // random words per phase setting
  localparam int RANDOM_SETS    = 5;    // phase settings drawn at random

  // Slot of each translation value inside a word
  localparam int T_HOME = 0;
  localparam int T_PY   = 1;
  localparam int T_MY   = 2;
  localparam int T_PZ   = 3;
  localparam int T_MZ   = 4;
  localparam int T_PYPZ = 5;
  localparam int T_PYMZ = 6;
  localparam int T_MYPZ = 7;
  localparam int T_MYMZ = 8;

  // Handy phase constants, Q2.30
  localparam logic signed [REG_W-1:0] PH_ONE   = 32'sh4000_0000;
  localparam logic signed [REG_W-1:0] PH_HALF  = 32'sh2000_0000;
  localparam logic signed [REG_W-1:0] PH_MONE  = -32'sh4000_0000;
  localparam logic signed [REG_W-1:0] PH_ZERO  = 32'sh0;

  localparam logic [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic                last;
    logic [8:0][VW-1:0]  val;
  } elem_t;

  typedef struct packed {
    logic [RW-1:0] re;
    logic [RW-1:0] im;
    logic          fin;
  } sum_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [REG_W-1:0]  pwdata  = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  logic          in_valid  = 1'b0;
  logic          in_stall;
  elem_t         in_word   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [RW-1:0] real_part;
  logic [RW-1:0] imag_part;
  logic          final_flag;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  bloch_phase_sum i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .home_value_i   (in_word.val[T_HOME]),
    .plus_y_value_i (in_word.val[T_PY]),
    .minus_y_value_i(in_word.val[T_MY]),
    .plus_z_value_i (in_word.val[T_PZ]),
    .minus_z_value_i(in_word.val[T_MZ]),
    .py_pz_value_i  (in_word.val[T_PYPZ]),
    .py_mz_value_i  (in_word.val[T_PYMZ]),
    .my_pz_value_i  (in_word.val[T_MYPZ]),
    .my_mz_value_i  (in_word.val[T_MYMZ]),
    .last_element_i (in_word.last),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .real_part_o    (real_part),
    .imag_part_o    (imag_part),
    .final_flag_o   (final_flag)
  );

  // --------------------------------------------------------------------------
  // Phase predictor: shadow copy of the registers plus the derived
  // sum-angle and difference-angle factors, all held 64 bits signed.
  // --------------------------------------------------------------------------
  logic signed [63:0] ph_cos_ky   = 64'sh4000_0000;
  logic signed [63:0] ph_sin_ky   = '0;
  logic signed [63:0] ph_cos_kz   = 64'sh4000_0000;
  logic signed [63:0] ph_sin_kz   = '0;
  logic signed [63:0] ph_sum_cos  = 64'sh4000_0000;
  logic signed [63:0] ph_sum_sin  = '0;
  logic signed [63:0] ph_diff_cos = 64'sh4000_0000;
  logic signed [63:0] ph_diff_sin = '0;

  // a*b / 2^FRAC, rounded to nearest with ties up; low 64 bits kept
  function automatic logic signed [63:0] round_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p + (128'sd1 <<< (FRAC - 1));
    return p[FRAC+63:FRAC];
  endfunction

  // derived factors clip to the 32-bit register range
  function automatic logic signed [63:0] clamp_reg(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  task automatic set_phase_reg(input cfg_reg_e idx, input logic signed [REG_W-1:0] value);
    logic signed [63:0] cc, ss, sc, cs;
    case (idx)
      REG_COS_KY: ph_cos_ky = 64'(value);
      REG_SIN_KY: ph_sin_ky = 64'(value);
      REG_COS_KZ: ph_cos_kz = 64'(value);
      default:    ph_sin_kz = 64'(value);
    endcase
    // angle addition, each product rounded on its own
    cc = round_mul(ph_cos_ky, ph_cos_kz);
    ss = round_mul(ph_sin_ky, ph_sin_kz);
    sc = round_mul(ph_sin_ky, ph_cos_kz);
    cs = round_mul(ph_cos_ky, ph_sin_kz);
    ph_sum_cos  = clamp_reg(cc - ss);
    ph_sum_sin  = clamp_reg(sc + cs);
    ph_diff_cos = clamp_reg(cc + ss);
    ph_diff_sin = clamp_reg(sc - cs);
  endtask

  // Real part pairs symmetric neighbors with cosines, imaginary part pairs
  // antisymmetric neighbors with sines. Sums wrap at the result width.
  function automatic sum_t predict_sum(elem_t w);
    logic signed [63:0] v [9];
    logic signed [63:0] re, im;
    sum_t s;
    for (int i = 0; i < 9; i++) v[i] = 64'($signed(w.val[i]));
    re = v[T_HOME]
       + round_mul(v[T_PY] + v[T_MY], ph_cos_ky)
       + round_mul(v[T_PZ] + v[T_MZ], ph_cos_kz)
       + round_mul(v[T_PYPZ] + v[T_MYMZ], ph_sum_cos)
       + round_mul(v[T_PYMZ] + v[T_MYPZ], ph_diff_cos);
    im = round_mul(v[T_PY] - v[T_MY], ph_sin_ky)
       + round_mul(v[T_PZ] - v[T_MZ], ph_sin_kz)
       + round_mul(v[T_PYPZ] - v[T_MYMZ], ph_sum_sin)
       + round_mul(v[T_PYMZ] - v[T_MYPZ], ph_diff_sin);
    s.re  = re[RW-1:0];
    s.im  = im[RW-1:0];
    s.fin = w.last;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard state
  // --------------------------------------------------------------------------
  elem_t pending_words [$];   // words waiting for the driver
  sum_t  expected_sums [$];   // predicted sums, oldest first
  sum_t  oldest_sum;
  int    mismatches   = 0;
  int    quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t mismatch: %s expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them. The payload
  // only moves once the current word has gone through.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid || !in_stall)) begin
      if (gap_left > 0 || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          // mostly short gaps, now and then a long one, often none
          gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24)
                                                 : $urandom_range(0, 2);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall: switches between no stall, coin-flip stall and long
  // stall runs, each mode held for a random stretch.
  // --------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 40;
  int          run_left   = 0;
  logic        run_hold   = 1'b0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(16, 160);
    end else begin
      mode_left--;
    end
    if (run_left > 0) begin
      run_left--;
    end else begin
      run_hold = !run_hold;
      run_left = run_hold ? $urandom_range(1, 40) : $urandom_range(1, 8);
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
      default:      out_stall <= run_hold;
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input acceptance, check on output acceptance.
  // Both sample pre-edge values, so event order within a step is moot.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) expected_sums.push_back(predict_sum(in_word));
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("word with nothing expected", '0, 64'(real_part));
      end else begin
        oldest_sum = expected_sums.pop_front();
        if (real_part !== oldest_sum.re)
          report_mismatch("real_part", 64'(oldest_sum.re), 64'(real_part));
        if (imag_part !== oldest_sum.im)
          report_mismatch("imag_part", 64'(oldest_sum.im), 64'(imag_part));
        if (final_flag !== oldest_sum.fin)
          report_mismatch("final_flag", 64'(oldest_sum.fin), 64'(final_flag));
      end
    end
  end

  // Watchdog: any handshake or register access counts as progress
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // APB write followed by a read back of the same register
  task automatic write_phase_reg(input cfg_reg_e idx, input logic signed [REG_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // back-to-back read, psel stays high
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      report_mismatch("register read back", 64'(unsigned'(value)), 64'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    set_phase_reg(idx, value);
  endtask

  // Wait for every word to be sent and answered, then let the pipe settle
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_sums.size() != 0 || in_valid)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_phases(input logic signed [REG_W-1:0] cy, sy, cz, sz);
    wait_drained();
    write_phase_reg(REG_COS_KY, cy);
    write_phase_reg(REG_SIN_KY, sy);
    write_phase_reg(REG_COS_KZ, cz);
    write_phase_reg(REG_SIN_KZ, sz);
  endtask

  task automatic queue_word(input logic [VW-1:0] h, py, my, pz, mz, pp, pm, mp, mm,
                            input logic last);
    elem_t w;
    w.val[T_HOME] = h;
    w.val[T_PY]   = py;
    w.val[T_MY]   = my;
    w.val[T_PZ]   = pz;
    w.val[T_MZ]   = mz;
    w.val[T_PYPZ] = pp;
    w.val[T_PYMZ] = pm;
    w.val[T_MYPZ] = mp;
    w.val[T_MYMZ] = mm;
    w.last        = last;
    pending_words.push_back(w);
  endtask

  function automatic logic [VW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return V_MAX;
      1:       return V_MIN;
      2:       return VW'(int'($urandom_range(0, 255)) - 128);
      3:       return '0;
      default: return VW'($urandom);
    endcase
  endfunction

  // Phase factor within [-1.0, 1.0], extremes weighted up
  function automatic logic signed [REG_W-1:0] random_phase();
    case ($urandom_range(0, 5))
      0:       return PH_ONE;
      1:       return PH_MONE;
      2:       return PH_ZERO;
      default: return REG_W'(longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824);
    endcase
  endfunction

  task automatic queue_random(input int count);
    elem_t w;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 9; i++) w.val[i] = random_value();
      // some words mirror or negate the partner so one part cancels
      case ($urandom_range(0, 5))
        0: begin
          w.val[T_MY]   = w.val[T_PY];
          w.val[T_MZ]   = w.val[T_PZ];
          w.val[T_MYMZ] = w.val[T_PYPZ];
          w.val[T_MYPZ] = w.val[T_PYMZ];
        end
        1: begin
          w.val[T_MY]   = -w.val[T_PY];
          w.val[T_MZ]   = -w.val[T_PZ];
          w.val[T_MYMZ] = -w.val[T_PYPZ];
          w.val[T_MYPZ] = -w.val[T_PYMZ];
        end
        default: ;
      endcase
      w.last = ($urandom_range(0, 7) == 0);
      pending_words.push_back(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset phases: identity weighting, sines zero
    queue_word('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    queue_word(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 1'b1);
    queue_word(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 1'b0);
    queue_word(V_MIN, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 1'b0);
    queue_word('0, VW'(1), '0, '0, '0, '0, '0, '0, '0, 1'b0);
    queue_word({(VW/2){2'b01}}, {(VW/2){2'b10}}, {(VW/2){2'b01}}, {(VW/2){2'b10}},
               {(VW/2){2'b01}}, {(VW/2){2'b10}}, {(VW/2){2'b01}}, {(VW/2){2'b10}},
               {(VW/2){2'b01}}, 1'b1);
    queue_random(RANDOM_PER_SET);

    // All factors 0.5: odd pair sums land exactly on half an LSB, so the
    // tie rule shows (+0.5 rounds up to 1, -0.5 rounds up to 0)
    set_phases(PH_HALF, PH_HALF, PH_HALF, PH_HALF);
    queue_word('0, VW'(1), '0, '0, '0, '0, '0, '0, '0, 1'b0);
    queue_word('0, -VW'(1), '0, '0, '0, '0, '0, '0, '0, 1'b0);
    queue_word('0, '0, '0, VW'(1), '0, '0, '0, '0, '0, 1'b0);
    queue_word('0, '0, '0, '0, '0, VW'(1), '0, '0, '0, 1'b0);
    queue_word('0, '0, '0, '0, '0, '0, VW'(1), -VW'(2), '0, 1'b0);
    queue_word(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 1'b1);
    queue_random(RANDOM_PER_SET);

    // Off the unit circle: cos(ky-kz) and sin(ky+kz) saturate high
    set_phases(PH_ONE, PH_ONE, PH_ONE, PH_ONE);
    queue_word(V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, V_MAX, 1'b0);
    queue_word(V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, V_MIN, 1'b1);
    queue_word(V_MAX, V_MAX, V_MIN, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN, V_MIN, 1'b0);
    queue_word(V_MIN, V_MIN, V_MAX, V_MIN, V_MAX, V_MIN, V_MIN, V_MAX, V_MAX, 1'b0);
    queue_word(V_MAX, '0, '0, '0, '0, V_MAX, V_MIN, V_MIN, V_MAX, 1'b1);
    queue_random(RANDOM_PER_SET);

    // Both axes at -1.0
    set_phases(PH_MONE, PH_MONE, PH_MONE, PH_MONE);
    queue_random(RANDOM_PER_SET);

    // sin(ky-kz) saturates low
    set_phases(PH_ONE, PH_MONE, PH_ONE, PH_ONE);
    queue_random(RANDOM_PER_SET);

    // Everything zero: only the home value survives
    set_phases(PH_ZERO, PH_ZERO, PH_ZERO, PH_ZERO);
    queue_random(RANDOM_PER_SET);

    // Pure sines, cosines zero
    set_phases(PH_ZERO, PH_ONE, PH_ZERO, PH_MONE);
    queue_random(RANDOM_PER_SET);

    for (int s = 0; s < RANDOM_SETS; s++) begin
      set_phases(random_phase(), random_phase(), random_phase(), random_phase());
      queue_random(RANDOM_PER_SET);
    end

    wait_drained();
    if (mismatches == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
